@@ rtl/core/lru_tag_table_two_area_defines.svh @@
// Assertion macros for the LRU tag table.
`ifndef LRU_TAG_TABLE_TWO_AREA_DEFINES_SVH
`define LRU_TAG_TABLE_TWO_AREA_DEFINES_SVH

// Clocked implication check, disabled while the active-low reset is low.
`define LTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check.
`define LTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ltt_pkg.sv @@
package ltt_pkg;
    localparam int LINK_ENTRIES_DEF = 16;
    localparam int DATA_ENTRIES_DEF = 32;
    localparam int STAMP_BITS_DEF   = 32;
    localparam int TAG_W   = 32;
    localparam int IDX_W   = 5;
    localparam int CFG_AW  = 3;

    localparam logic [1:0] CMD_FIND    = 2'd0;
    localparam logic [1:0] CMD_ALLOC   = 2'd1;
    localparam logic [1:0] CMD_VICTIM  = 2'd2;
    localparam logic [1:0] CMD_DISCARD = 2'd3;

    localparam logic [CFG_AW-1:0] REG_LINK_USED = 3'd0;
    localparam logic [CFG_AW-1:0] REG_DATA_USED = 3'd4;

    typedef struct packed {
        logic [1:0]       command;
        logic             area;
        logic [TAG_W-1:0] tag;
    } t_req;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] entry_index;
        logic             evicted_valid;
        logic [TAG_W-1:0] evicted_tag;
    } t_rsp;
endpackage

@@ rtl/core/ltt_if.sv @@
interface ltt_req_if;
    logic            valid;
    logic            ready;
    ltt_pkg::t_req   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ltt_rsp_if;
    logic            valid;
    logic            ready;
    ltt_pkg::t_rsp   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/lru_tag_table_two_area.sv @@
// LRU tag table, two areas (link table area 0, data area 1).
// Request channel i_req carries command, area and tag; response channel o_rsp
// returns one transfer per request: found, entry_index, evicted_valid and
// evicted_tag. Registers on the APB port: link_entries_used at 0x0 and
// data_entries_used at 0x4; write them only while the block is idle.
// Each find, allocate or victim request reads the area's entries one per cycle
// from a memory with registered reads and a separate write port.
// Find/allocate/victim on an area whose counter reached the top-2 level first
// renormalize: each of the used entries is ranked against all others by a
// second sweep, ranks go to a small rank memory and are copied back to the
// stamps at the end.
// Discard all only clears the area's valid flags and its counter.
// Reset clears valid flags, stamps (by a valid-for-stamp flag) and counters;
// the block then accepts requests right away. A stalled response holds in its
// output register; no new request is taken until the response transfers.
`include "lru_tag_table_two_area_defines.svh"
module lru_tag_table_two_area #(
    parameter int LINK_ENTRIES = ltt_pkg::LINK_ENTRIES_DEF,
    parameter int DATA_ENTRIES = ltt_pkg::DATA_ENTRIES_DEF,
    parameter int STAMP_BITS   = ltt_pkg::STAMP_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ltt_req_if.sink                    i_req,
    ltt_rsp_if.source                  o_rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ltt_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import ltt_pkg::*;

    localparam int MAXE  = (LINK_ENTRIES > DATA_ENTRIES) ? LINK_ENTRIES : DATA_ENTRIES;
    localparam int EW    = $clog2(MAXE);
    localparam int AW    = EW + 1;
    localparam int DEPTH = 2 * MAXE;
    localparam int CW    = EW + 1;
    localparam logic [STAMP_BITS-1:0] RENORM_LVL = {{(STAMP_BITS-1){1'b1}}, 1'b0};

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_WAIT  = 4'd2;
    localparam logic [3:0] S_DONE  = 4'd3;
    localparam logic [3:0] S_RI    = 4'd4;
    localparam logic [3:0] S_RIW   = 4'd5;
    localparam logic [3:0] S_RJ    = 4'd6;
    localparam logic [3:0] S_RWB   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_CPR   = 4'd9;
    localparam logic [3:0] S_CPW   = 4'd10;

    // entry memory: tag and stamp
    logic [TAG_W-1:0]      m_tag   [DEPTH];
    logic [STAMP_BITS-1:0] m_stamp [DEPTH];
    logic [CW-1:0]         m_rank  [MAXE];
    logic [TAG_W-1:0]      r_rd_tag;
    logic [STAMP_BITS-1:0] r_rd_stamp;
    logic [CW-1:0]         r_rd_rank;
    logic                  mem_we;
    logic                  mem_we_tag;
    logic [AW-1:0]         mem_waddr;
    logic [AW-1:0]         mem_raddr;
    logic [TAG_W-1:0]      mem_wtag;
    logic [STAMP_BITS-1:0] mem_wstamp;

    // valid bits and "stamp written" bits; unwritten stamps read as zero
    logic [DEPTH-1:0]      r_valid;
    logic [DEPTH-1:0]      r_sv;
    logic [STAMP_BITS-1:0] r_cnt [2];
    logic [4:0]            r_link_used;
    logic [5:0]            r_data_used;

    logic [3:0]            r_state;
    logic [1:0]            r_cmd;
    logic                  r_area;
    logic [TAG_W-1:0]      r_tag;
    logic [CW-1:0]         r_used;
    logic [CW-1:0]         r_i;
    logic [CW-1:0]         r_j;
    logic [CW-1:0]         r_lag;
    logic                  r_lag_v;
    logic                  r_hit;
    logic [EW-1:0]         r_best;
    logic [STAMP_BITS-1:0] r_best_stamp;
    logic [TAG_W-1:0]      r_best_tag;
    logic                  r_empty;
    logic [STAMP_BITS-1:0] r_si;
    logic [STAMP_BITS-1:0] r_rank;
    logic                  r_ovalid;
    t_rsp                  r_rsp;

    logic [CW-1:0]         used_now;
    logic [AW-1:0]         lag_addr;
    logic                  lag_valid;
    logic [STAMP_BITS-1:0] lag_stamp;
    logic                  req_xfer;
    logic                  cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (paddr == REG_LINK_USED) ? {27'd0, r_link_used} :
                     (paddr == REG_DATA_USED) ? {26'd0, r_data_used} : 32'd0;

    always_comb begin
        logic [5:0] raw;
        logic [6:0] sz;
        raw = i_req.payload.area ? r_data_used : {1'b0, r_link_used};
        sz  = i_req.payload.area ? 7'(DATA_ENTRIES) : 7'(LINK_ENTRIES);
        if (raw == 6'd0) begin
            used_now = CW'(1);
        end else if ({1'b0, raw} > sz) begin
            used_now = CW'(sz);
        end else begin
            used_now = CW'(raw);
        end
    end

    assign i_req.ready  = (r_state == S_IDLE) && !r_ovalid;
    assign req_xfer     = i_req.valid && i_req.ready;
    assign o_rsp.valid  = r_ovalid;
    assign o_rsp.payload = r_rsp;

    assign lag_addr  = {r_area, r_lag[EW-1:0]};
    assign lag_valid = r_valid[lag_addr];
    assign lag_stamp = r_sv[lag_addr] ? r_rd_stamp : '0;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_stamp[mem_waddr] <= mem_wstamp;
            if (mem_we_tag) begin
                m_tag[mem_waddr] <= mem_wtag;
            end
        end
        r_rd_tag   <= m_tag[mem_raddr];
        r_rd_stamp <= m_stamp[mem_raddr];
        if (r_state == S_RWB) begin
            m_rank[r_i[EW-1:0]] <= CW'(r_rank);
        end
        r_rd_rank <= m_rank[r_i[EW-1:0]];
    end

    always_comb begin
        mem_raddr  = {r_area, r_j[EW-1:0]};
        mem_we     = 1'b0;
        mem_we_tag = 1'b0;
        mem_waddr  = {r_area, r_best};
        mem_wtag   = r_tag;
        mem_wstamp = r_cnt[r_area];
        if (r_state == S_CPW) begin
            mem_we     = 1'b1;
            mem_waddr  = {r_area, r_i[EW-1:0]};
            mem_wstamp = STAMP_BITS'(r_rd_rank);
        end else if (r_state == S_RIW || r_state == S_RI) begin
            mem_raddr = {r_area, r_i[EW-1:0]};
        end else if (r_state == S_DONE && r_hit) begin
            mem_we     = 1'b1;
            mem_we_tag = (r_cmd != CMD_FIND);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_sv        <= '0;
            r_cnt[0]    <= '0;
            r_cnt[1]    <= '0;
            r_link_used <= 5'd16;
            r_data_used <= 6'd32;
            r_ovalid    <= 1'b0;
        end else begin
            if (cfg_wr && paddr == REG_LINK_USED) begin
                r_link_used <= pwdata[4:0];
            end
            if (cfg_wr && paddr == REG_DATA_USED) begin
                r_data_used <= pwdata[5:0];
            end
            if (o_rsp.valid && o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (req_xfer) begin
                        r_cmd   <= i_req.payload.command;
                        r_area  <= i_req.payload.area;
                        r_tag   <= i_req.payload.tag;
                        r_used  <= used_now;
                        r_j     <= '0;
                        r_i     <= '0;
                        r_lag_v <= 1'b0;
                        r_hit   <= 1'b0;
                        r_empty <= 1'b0;
                        r_best  <= '0;
                        if (i_req.payload.command == CMD_DISCARD) begin
                            for (int k = 0; k < MAXE; k++) begin
                                r_valid[{i_req.payload.area, EW'(k)}] <= 1'b0;
                            end
                            r_cnt[i_req.payload.area] <= '0;
                            r_state <= S_OUT;
                        end else if (r_cnt[i_req.payload.area] >= RENORM_LVL) begin
                            r_state <= S_RI;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                // renormalize: read entry i, then sweep j over all used entries
                S_RI: begin
                    r_j     <= '0;
                    r_rank  <= '0;
                    r_lag_v <= 1'b0;
                    r_state <= S_RIW;
                end
                S_RIW: begin
                    r_si    <= r_sv[{r_area, r_i[EW-1:0]}] ? r_rd_stamp : '0;
                    r_state <= S_RJ;
                end
                S_RJ: begin
                    if (r_lag_v) begin
                        if (lag_stamp < r_si || (lag_stamp == r_si && r_lag < r_i)) begin
                            r_rank <= r_rank + 1'b1;
                        end
                    end
                    r_lag   <= r_j;
                    r_lag_v <= (r_j < r_used);
                    if (r_j < r_used) begin
                        r_j <= r_j + 1'b1;
                    end else if (!r_lag_v) begin
                        r_state <= S_RWB;
                    end
                end
                S_RWB: begin
                    if (r_i + 1'b1 < r_used) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_RI;
                    end else begin
                        r_i     <= '0;
                        r_state <= S_CPR;
                    end
                end
                // copy ranks back into the stamps
                S_CPR: begin
                    r_state <= S_CPW;
                end
                S_CPW: begin
                    r_sv[{r_area, r_i[EW-1:0]}] <= 1'b1;
                    if (r_i + 1'b1 < r_used) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_CPR;
                    end else begin
                        r_cnt[r_area] <= STAMP_BITS'(r_used);
                        r_j     <= '0;
                        r_lag_v <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN, S_WAIT: begin
                    if (r_lag_v && !r_hit && !r_empty) begin
                        if (r_cmd == CMD_FIND) begin
                            if (lag_valid && r_rd_tag == r_tag) begin
                                r_hit  <= 1'b1;
                                r_best <= r_lag[EW-1:0];
                            end
                        end else if (r_cmd == CMD_ALLOC) begin
                            if (!lag_valid) begin
                                r_hit  <= 1'b1;
                                r_best <= r_lag[EW-1:0];
                            end
                        end else begin
                            if (!lag_valid) begin
                                r_empty <= 1'b1;
                                r_best  <= r_lag[EW-1:0];
                            end else if (r_lag == '0 || lag_stamp < r_best_stamp) begin
                                r_best       <= r_lag[EW-1:0];
                                r_best_stamp <= lag_stamp;
                                r_best_tag   <= r_rd_tag;
                            end
                        end
                    end
                    r_lag   <= r_j;
                    r_lag_v <= (r_j < r_used);
                    if (r_j < r_used) begin
                        r_j <= r_j + 1'b1;
                    end else if (!r_lag_v) begin
                        if (r_cmd == CMD_VICTIM) begin
                            r_hit <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (r_hit) begin
                        r_valid[{r_area, r_best}] <= 1'b1;
                        r_sv[{r_area, r_best}]    <= 1'b1;
                        r_cnt[r_area]             <= r_cnt[r_area] + 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT) begin
            r_rsp.found         <= (r_cmd != CMD_DISCARD) && r_hit;
            r_rsp.entry_index   <= ((r_cmd != CMD_DISCARD) && r_hit) ? IDX_W'(r_best) : '0;
            r_rsp.evicted_valid <= (r_cmd == CMD_VICTIM) && !r_empty;
            r_rsp.evicted_tag   <= ((r_cmd == CMD_VICTIM) && !r_empty) ? r_best_tag : '0;
        end
    end

    `LTT_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !i_req.ready, "request taken while busy")
    `LTT_ASSERT_NEXT(a_out_follows, i_clk, i_rst_n, r_state == S_OUT, o_rsp.valid, "response missing after finish")
    `LTT_ASSERT_IMP(a_evict_victim, i_clk, i_rst_n, o_rsp.valid && o_rsp.payload.evicted_valid, o_rsp.payload.found, "eviction without grant")
endmodule

@@ dv/ltt_scoreboard.sv @@
`timescale 1ns / 100ps

module ltt_scoreboard (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ltt_req_if                         i_req,
    ltt_rsp_if                         i_rsp,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic                       i_pready,
    input  logic [ltt_pkg::CFG_AW-1:0] i_paddr,
    input  logic [31:0]                i_pwdata,
    output int                         o_fail_count,
    output int                         o_pending
);
    import ltt_pkg::*;

    localparam logic [31:0] RENORM_LEVEL = 32'hFFFF_FFFE;

    logic        ent_valid [2][32];
    logic [31:0] ent_tag   [2][32];
    logic [31:0] ent_stamp [2][32];
    logic [31:0] access_cnt [2];
    logic [4:0]  link_used_reg;
    logic [5:0]  data_used_reg;
    t_rsp        lookup_q [$];

    function automatic int area_size(logic a);
        return a ? DATA_ENTRIES_DEF : LINK_ENTRIES_DEF;
    endfunction

    function automatic int eff_used(logic a);
        int raw;
        raw = a ? int'(data_used_reg) : int'(link_used_reg);
        if (raw == 0) return 1;
        if (raw > area_size(a)) return area_size(a);
        return raw;
    endfunction

    function automatic void rerank(logic a, int n);
        logic [31:0] rank [32];
        if (access_cnt[a] < RENORM_LEVEL) return;
        for (int i = 0; i < n; i++) begin
            rank[i] = 0;
            for (int j = 0; j < n; j++)
                if (ent_stamp[a][j] < ent_stamp[a][i] ||
                    (ent_stamp[a][j] == ent_stamp[a][i] && j < i))
                    rank[i]++;
        end
        for (int i = 0; i < n; i++) ent_stamp[a][i] = rank[i];
        access_cnt[a] = n;
    endfunction

    function automatic void touch(logic a, int idx);
        ent_stamp[a][idx] = access_cnt[a];
        access_cnt[a] = access_cnt[a] + 1;
    endfunction

    function automatic t_rsp predict_lookup(t_req r);
        t_rsp res;
        int   n;
        int   best;
        logic empty;
        res = '0;
        n = eff_used(r.area);
        if (r.command == CMD_DISCARD) begin
            for (int i = 0; i < 32; i++) ent_valid[r.area][i] = 1'b0;
            access_cnt[r.area] = 0;
            return res;
        end
        rerank(r.area, n);
        case (r.command)
            CMD_FIND: begin
                for (int i = 0; i < n; i++)
                    if (ent_valid[r.area][i] && ent_tag[r.area][i] == r.tag) begin
                        res.found = 1'b1;
                        res.entry_index = i[4:0];
                        touch(r.area, i);
                        break;
                    end
            end
            CMD_ALLOC: begin
                for (int i = 0; i < n; i++)
                    if (!ent_valid[r.area][i]) begin
                        res.found = 1'b1;
                        res.entry_index = i[4:0];
                        ent_valid[r.area][i] = 1'b1;
                        ent_tag[r.area][i] = r.tag;
                        touch(r.area, i);
                        break;
                    end
            end
            default: begin
                best = 0;
                empty = 1'b0;
                for (int i = 0; i < n; i++) begin
                    if (!ent_valid[r.area][i]) begin
                        best = i;
                        empty = 1'b1;
                        break;
                    end
                    if (ent_stamp[r.area][i] < ent_stamp[r.area][best]) best = i;
                end
                if (!empty) begin
                    res.evicted_valid = 1'b1;
                    res.evicted_tag = ent_tag[r.area][best];
                end
                res.found = 1'b1;
                res.entry_index = best[4:0];
                ent_valid[r.area][best] = 1'b1;
                ent_tag[r.area][best] = r.tag;
                touch(r.area, best);
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            for (int a = 0; a < 2; a++) begin
                for (int i = 0; i < 32; i++) begin
                    ent_valid[a][i] = 1'b0;
                    ent_tag[a][i] = '0;
                    ent_stamp[a][i] = '0;
                end
                access_cnt[a] = '0;
            end
            link_used_reg = 5'd16;
            data_used_reg = 6'd32;
            lookup_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == REG_LINK_USED) link_used_reg = i_pwdata[4:0];
                else if (i_paddr == REG_DATA_USED) data_used_reg = i_pwdata[5:0];
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got = i_rsp.payload;
                if (lookup_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected response transfer: %p", got);
                end else begin
                    want = lookup_q.pop_front();
                    if (got.found !== want.found || got.entry_index !== want.entry_index ||
                        got.evicted_valid !== want.evicted_valid ||
                        got.evicted_tag !== want.evicted_tag) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                lookup_q.push_back(predict_lookup(i_req.payload));
        end
        o_pending = lookup_q.size();
    end
endmodule

@@ dv/tb_lru_tag_table_two_area.sv @@
`timescale 1ns / 100ps

module tb_lru_tag_table_two_area;
    import ltt_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [CFG_AW-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    int                  fail_count;
    int                  pending;
    int                  cycles = 0;
    int                  stall_left = 0;
    bit                  rsp_taken;
    logic                quiet = 1'b0;
    logic [31:0]         tag_pool [8];

    ltt_req_if req_bus ();
    ltt_rsp_if rsp_bus ();

    lru_tag_table_two_area dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ltt_scoreboard checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_bus),
        .i_rsp        (rsp_bus),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_lru_tag_table_two_area NOT OK");
            $finish;
        end
        rsp_taken = rsp_bus.valid && rsp_bus.ready;
    end

    always @(negedge i_clk) begin
        if (rsp_taken)
            stall_left = quiet ? 0 : $urandom_range(0, 10);
        if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
        end else begin
            rsp_bus.ready = 1'b1;
        end
    end

    task automatic send_lookup(logic [1:0] c, logic a, logic [31:0] t);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            @(negedge i_clk) req_bus.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_bus.valid = 1'b1;
        req_bus.payload.command = c;
        req_bus.payload.area = a;
        req_bus.payload.tag = t;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [CFG_AW-1:0] addr, logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = value;
        @(negedge i_clk) penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // drain, then reconfigure both areas
    task automatic set_used(logic [4:0] link_n, logic [5:0] data_n);
        @(negedge i_clk) req_bus.valid = 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        apb_write(REG_LINK_USED, {27'($urandom_range(0, 32'h7FF_FFFF)), link_n});
        apb_write(REG_DATA_USED, {26'($urandom_range(0, 32'h3FF_FFFF)), data_n});
    endtask

    task automatic random_phase(int count);
        logic [1:0]  c;
        logic [31:0] t;
        int          pick;
        for (int i = 0; i < 8; i++) tag_pool[i] = $urandom;
        tag_pool[0] = 32'h0;
        tag_pool[1] = 32'hFFFF_FFFF;
        for (int k = 0; k < count; k++) begin
            if (k % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 40) c = CMD_FIND;
            else if (pick < 65) c = CMD_ALLOC;
            else if (pick < 97) c = CMD_VICTIM;
            else c = CMD_DISCARD;
            t = ($urandom_range(0, 3) == 0) ? $urandom : tag_pool[$urandom_range(0, 7)];
            send_lookup(c, 1'($urandom_range(0, 1)), t);
        end
        quiet = 1'b0;
    endtask

    initial begin
        req_bus.valid = 1'b0;
        req_bus.payload = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // small tables: full allocate, evict oldest, hit refresh, discard
        set_used(5'd2, 6'd3);
        for (int a = 0; a < 2; a++) begin
            send_lookup(CMD_FIND, 1'(a), 32'h0);
            send_lookup(CMD_ALLOC, 1'(a), 32'h0);
            send_lookup(CMD_ALLOC, 1'(a), 32'hFFFF_FFFF);
            send_lookup(CMD_ALLOC, 1'(a), 32'h5A5A_A5A5);
            send_lookup(CMD_ALLOC, 1'(a), 32'h1234_5678);
            send_lookup(CMD_FIND, 1'(a), 32'h0);
            send_lookup(CMD_VICTIM, 1'(a), 32'hDEAD_BEEF);
            send_lookup(CMD_FIND, 1'(a), 32'hFFFF_FFFF);
            send_lookup(CMD_VICTIM, 1'(a), 32'h0);
            send_lookup(CMD_DISCARD, 1'(a), 32'h0);
            send_lookup(CMD_FIND, 1'(a), 32'h0);
            send_lookup(CMD_VICTIM, 1'(a), 32'h8000_0001);
        end

        set_used(5'd16, 6'd32);
        random_phase(200);
        set_used(5'd1, 6'd1);
        random_phase(120);
        set_used(5'd0, 6'd0);
        random_phase(100);
        set_used(5'd31, 6'd63);
        random_phase(200);
        set_used(5'd5, 6'd17);
        random_phase(180);
        set_used(5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
        random_phase(180);

        @(negedge i_clk) req_bus.valid = 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_lru_tag_table_two_area OK");
        else
            $display("tb_lru_tag_table_two_area NOT OK");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/ltt_pkg.sv
rtl/core/ltt_if.sv
rtl/core/lru_tag_table_two_area.sv
dv/ltt_scoreboard.sv
dv/tb_lru_tag_table_two_area.sv
